FILE: design/cnfm_pkg.sv
// ----------------------------------------------------------------------------
// cnfm_pkg
// Shared types and constants of the three-input CNF minimiser: clause count,
// mask width, the operation codes of the shared step unit and its request.
// ----------------------------------------------------------------------------
package cnfm_pkg;

    localparam int NUM_CLAUSES = 8;
    localparam int IDX_W       = 3;
    localparam int MASK_W      = 4;
    localparam int CODE_W      = NUM_CLAUSES * MASK_W;

    localparam logic [MASK_W-1:0] FULL_MASK = 4'hF;

    // Operation carried out by the shared step unit.
    typedef enum logic {
        OP_SIMPLIFY = 1'b0,
        OP_RESOLVE  = 1'b1
    } op_t;

    // One request to the step unit: operation and the two clause indices.
    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] idx_a;
        logic [IDX_W-1:0] idx_b;
    } step_req_t;

endpackage

FILE: design/cnfm_step_unit.sv
// ----------------------------------------------------------------------------
// cnfm_step_unit
// Shared combinational step: one subsumption / self-resolution step on a
// clause pair, or one pairwise resolution with removal of subsumed clauses.
// ----------------------------------------------------------------------------
module cnfm_step_unit (
    input  cnfm_pkg::step_req_t                 req,
    input  logic [cnfm_pkg::CODE_W-1:0]         masks,
    input  logic [cnfm_pkg::NUM_CLAUSES-1:0]    vals,
    output logic [cnfm_pkg::CODE_W-1:0]         masks_next,
    output logic                                changed
);

    logic [cnfm_pkg::MASK_W-1:0] m  [cnfm_pkg::NUM_CLAUSES];
    logic [cnfm_pkg::MASK_W-1:0] mn [cnfm_pkg::NUM_CLAUSES];
    logic [cnfm_pkg::MASK_W-1:0] ma;
    logic [cnfm_pkg::MASK_W-1:0] mb;
    logic                        va;
    logic                        vb;
    logic [cnfm_pkg::MASK_W-1:0] d_s;
    logic [cnfm_pkg::MASK_W-1:0] d_r;
    logic [cnfm_pkg::MASK_W-1:0] keep;
    logic [cnfm_pkg::IDX_W-1:0]  row;

    function automatic logic single_literal(input logic [cnfm_pkg::MASK_W-1:0] d);
        return (d == 4'd1) || (d == 4'd2) || (d == 4'd4);
    endfunction

    always_comb begin
        for (int r = 0; r < cnfm_pkg::NUM_CLAUSES; r++) begin
            m[r] = masks[r*cnfm_pkg::MASK_W +: cnfm_pkg::MASK_W];
        end
    end

    assign ma   = m[req.idx_a];
    assign mb   = m[req.idx_b];
    assign va   = vals[req.idx_a];
    assign vb   = vals[req.idx_b];
    assign d_s  = {1'b0, req.idx_a ^ req.idx_b} & ma;
    assign d_r  = {1'b0, req.idx_a ^ req.idx_b} & ma & mb & 4'h7;
    assign keep = (ma | mb) ^ d_r;
    assign row  = ((req.idx_a & ma[2:0]) | (req.idx_b & mb[2:0])) ^ d_r[2:0];

    always_comb begin
        for (int r = 0; r < cnfm_pkg::NUM_CLAUSES; r++) begin
            mn[r] = m[r];
        end
        changed = 1'b0;
        unique case (req.op)
            cnfm_pkg::OP_SIMPLIFY: begin
                // Clause a subsumes or strengthens clause b.
                if (req.idx_a != req.idx_b && va == vb && ma != '0 && mb != '0 &&
                    (ma & mb) == ma) begin
                    if (d_s == '0) begin
                        mn[req.idx_b] = '0;
                        changed       = 1'b1;
                    end else if (single_literal(d_s)) begin
                        mn[req.idx_b] = mb ^ d_s;
                        changed       = 1'b1;
                    end
                end
            end
            cnfm_pkg::OP_RESOLVE: begin
                // The resolvent removes every clause that it subsumes.
                if (ma != '0 && mb != '0 && va == vb && single_literal(d_r)) begin
                    for (int r = 0; r < cnfm_pkg::NUM_CLAUSES; r++) begin
                        if (m[r] != '0 && vals[r] == va && (keep & m[r]) == keep &&
                            ((cnfm_pkg::IDX_W'(r) ^ row) & keep[2:0]) == '0) begin
                            mn[r]   = '0;
                            changed = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int r = 0; r < cnfm_pkg::NUM_CLAUSES; r++) begin
            masks_next[r*cnfm_pkg::MASK_W +: cnfm_pkg::MASK_W] = mn[r];
        end
    end

endmodule

FILE: design/three_input_cnf_minimizer.sv
// ----------------------------------------------------------------------------
// three_input_cnf_minimizer
// Minimises the row-clause CNF of a three-input function by a subsumption
// fixpoint followed by a redundancy-removal fixpoint, one step per cycle.
// ----------------------------------------------------------------------------
// Sequence: the subsumption pass over all ordered pairs repeats until a
//   pass changes nothing, then the redundancy pass over pairs a < b repeats
//   likewise before the output register is loaded; the loop counts depend on the table.
// Throughput: one request at a time; the next is taken once the sequencer
//   has placed the previous result in the output register.
// Reset: synchronous, active low; clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module three_input_cnf_minimizer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_truth_table,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [cnfm_pkg::CODE_W-1:0]   m_base_code,
    output logic [cnfm_pkg::CODE_W-1:0]   m_reduced_code
);

    // One-hot sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SUB  = 4'b0010,
        ST_RED  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                              state_reg, state_next;
    logic [cnfm_pkg::CODE_W-1:0]         mask_reg, mask_next;
    logic [cnfm_pkg::NUM_CLAUSES-1:0]    val_reg;
    logic [cnfm_pkg::IDX_W-1:0]          a_reg, a_next;
    logic [cnfm_pkg::IDX_W-1:0]          b_reg, b_next;
    logic                                any_reg, any_next;
    logic [cnfm_pkg::CODE_W-1:0]         base_reg;
    logic                                out_valid_reg;
    logic [cnfm_pkg::CODE_W-1:0]         out_base_reg;
    logic [cnfm_pkg::CODE_W-1:0]         out_red_reg;

    cnfm_pkg::step_req_t                 req;
    logic [cnfm_pkg::CODE_W-1:0]         unit_masks;
    logic                                unit_changed;
    logic                                pass_any;
    logic                                accept;
    logic                                load_out;

    assign s_ready        = (state_reg == ST_IDLE);
    assign accept         = s_valid && s_ready;
    assign m_valid        = out_valid_reg;
    assign m_base_code    = out_base_reg;
    assign m_reduced_code = out_red_reg;

    // The one shared step unit serves both phases; the state picks the operation.
    assign req.op    = (state_reg == ST_RED) ? cnfm_pkg::OP_RESOLVE : cnfm_pkg::OP_SIMPLIFY;
    assign req.idx_a = a_reg;
    assign req.idx_b = b_reg;

    cnfm_step_unit u_step (
        .req        (req),
        .masks      (mask_reg),
        .vals       (val_reg),
        .masks_next (unit_masks),
        .changed    (unit_changed)
    );

    // Whether anything in the current pass changed, including this step.
    assign pass_any = any_reg || unit_changed;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        mask_next  = mask_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        any_next   = any_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SUB;
                    mask_next  = {cnfm_pkg::NUM_CLAUSES{cnfm_pkg::FULL_MASK}};
                    a_next     = '0;
                    b_next     = '0;
                    any_next   = 1'b0;
                end
            end
            ST_SUB: begin
                // Clause a acts on every clause b in turn, a then advances.
                mask_next = unit_masks;
                b_next    = b_reg + 3'd1;
                any_next  = pass_any;
                if (b_reg == 3'd7) begin
                    a_next = a_reg + 3'd1;
                    if (a_reg == 3'd7) begin
                        any_next = 1'b0;
                        if (!pass_any) begin
                            // Fixpoint reached: start the pair sweep at (0,1).
                            state_next = ST_RED;
                            a_next     = 3'd0;
                            b_next     = 3'd1;
                        end
                    end
                end
            end
            ST_RED: begin
                // Pairs (a,b) with a < b in the nested order of the sweep.
                mask_next = unit_masks;
                any_next  = pass_any;
                b_next    = b_reg + 3'd1;
                if (b_reg == 3'd7) begin
                    a_next = a_reg + 3'd1;
                    b_next = a_reg + 3'd2;
                    if (a_reg == 3'd6) begin
                        any_next = 1'b0;
                        a_next   = 3'd0;
                        b_next   = 3'd1;
                        if (!pass_any) begin
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
            any_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            any_reg   <= any_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mask_reg <= mask_next;
        if (accept) begin
            val_reg <= s_truth_table;
        end
        // The base code is the mask set at the moment the first phase ends.
        if (state_reg == ST_SUB && state_next == ST_RED) begin
            base_reg <= unit_masks;
        end
        if (load_out) begin
            out_base_reg <= base_reg;
            out_red_reg  <= mask_reg;
        end
    end

    // An accepted request always starts the subsumption phase.
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_SUB)
        else $error("accepted request did not start the subsumption phase");

    // While working, masks only ever lose bits.
    a_masks_shrink: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUB || state_reg == ST_RED) |=>
            ((mask_reg & ~$past(mask_reg)) == '0))
        else $error("a clause mask gained a bit during minimisation");

    // Redundancy removal only deletes clauses of the base set.
    a_reduced_subset: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ((out_red_reg & ~out_base_reg) == '0))
        else $error("reduced code holds bits absent from the base code");

    // A new result appears only when the sequencer hands one over.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (!out_valid_reg ##1 out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result became valid without a finished computation");

endmodule
